// ----- rtl/gdd_pkg.sv -----
// Shared types and constants for the grid disk dilation block.
`default_nettype none
package gdd_pkg;

    localparam int ROW_BITS     = 64;  // port width of one grid row
    localparam int GW_W         = 7;   // grid_width register width
    localparam int RSQ_W        = 16;  // radius_sq_q8 register width
    localparam int RADIUS_INT_W = 8;   // integer part of radius_sq_q8
    localparam int D2_W         = 12;  // holds dx*dx+dy*dy for radius up to 31
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH   = 4'd0,
        REG_RADIUS_SQ_Q8 = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_bits;
        logic                last_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] out_row;
        logic                out_last;
    } out_item_t;

    // Control broadcast to every cell of the row window.
    typedef struct packed {
        logic shift;  // take the neighbor's row
        logic clear;  // zero the cell after this cycle's contribution
    } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/gdd_cell.sv -----
// One row cell of the dilation window: stores a row and forms its disk contribution.
`default_nettype none
module gdd_cell #(
    parameter int ROW_W = 64,
    parameter int MAX_R = 8,
    parameter int IDX   = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gdd_pkg::cell_ctl_t               ctl,
    input  logic [ROW_W-1:0]                 d_in,
    input  logic [gdd_pkg::RADIUS_INT_W-1:0] radius_cells,
    output logic [ROW_W-1:0]                 q,
    output logic [ROW_W-1:0]                 contrib
);
    import gdd_pkg::*;

    localparam int DY = IDX - MAX_R;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] row_cur;
    logic [MAX_R:0]   dx_en;

    // Row as seen this cycle: the shifted-in value when the window moves.
    assign row_cur = ctl.shift ? d_in : row_reg;

    // dx*dx + dy*dy <= floor(radius_sq_q8 / 256)
    for (genvar dx = 0; dx <= MAX_R; dx++) begin : g_dx
        assign dx_en[dx] = (D2_W'(dx * dx + DY * DY) <= D2_W'(radius_cells));
    end

    always_comb begin
        contrib = '0;
        for (int dx = 0; dx <= MAX_R; dx++) begin
            if (dx_en[dx]) begin
                contrib = contrib | (row_cur << dx) | (row_cur >> dx);
            end
        end
    end

    assign row_next = ctl.clear ? '0 : row_cur;
    assign q        = row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/grid_obstacle_disk_dilation.sv -----
// Streaming disk dilation of an occupancy grid, one row per transfer. Rows enter at one
// per cycle, save during a flush or a stall of the result port, into a chain of
// 2*MAX_RADIUS+1 row cells; the dilated row for input row y is registered in the cycle that
// input row y+MAX_RADIUS is accepted, so a frame's first MAX_RADIUS rows produce nothing at
// first. A row with last_row set starts a flush in which zero rows shift through the chain
// and all pending rows leave (at most MAX_RADIUS+1 results, the final one with out_last); no
// input is taken during the flush, and the chain is cleared at the end. Output throughput is
// one row per cycle; a stalled result port stalls the input port. The user must write
// grid_width and radius_sq_q8 over the cfg port while the block is idle; the block does not enforce this.
`default_nettype none
module grid_obstacle_disk_dilation #(
    parameter int MAX_RADIUS = 8,
    parameter int ROW_WIDTH  = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gdd_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output gdd_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gdd_pkg::*;

    localparam int WIN   = 2 * MAX_RADIUS;
    localparam int CNT_W = $clog2(MAX_RADIUS + 1);
    localparam logic [CNT_W-1:0] R_CNT = CNT_W'(MAX_RADIUS);

    // configuration
    logic [GW_W-1:0]  grid_width_reg;
    logic [RSQ_W-1:0] radius_sq_reg;

    // control
    logic [CNT_W-1:0] rows_seen_reg, rows_seen_next;
    logic             flushing_reg, flushing_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] skip_reg, skip_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic                 out_free;
    logic                 acc;
    logic                 flush_step;
    logic                 emit;
    logic                 emit_last;
    cell_ctl_t            ctl;
    logic [ROW_WIDTH-1:0] row_mask;
    logic [ROW_WIDTH-1:0] top_in;
    logic [ROW_WIDTH-1:0] dilated;
    logic [ROW_WIDTH-1:0] cell_q       [0:WIN];
    logic [ROW_WIDTH-1:0] cell_contrib [0:WIN];

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg <= GW_W'(64);
            radius_sq_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_width_reg <= cfg_data[GW_W-1:0];
                REG_RADIUS_SQ_Q8: radius_sq_reg  <= cfg_data[RSQ_W-1:0];
                default:          ;
            endcase
        end
    end

    for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_mask
        assign row_mask[j] = (GW_W'(j) < grid_width_reg);
    end

    // handshake
    assign out_free   = !out_valid_reg || m_ready;
    assign s_ready    = !flushing_reg && out_free;
    assign acc        = s_valid && s_ready;
    assign flush_step = flushing_reg && out_free;

    assign ctl.shift = acc || flush_step;
    assign ctl.clear = flush_step && (step_reg == R_CNT);

    assign top_in = acc ? (s_data.row_bits[ROW_WIDTH-1:0] & row_mask) : '0;

    // row window
    for (genvar i = 0; i <= WIN; i++) begin : g_cell
        logic [ROW_WIDTH-1:0] nbr;
        if (i == WIN) begin : g_top
            assign nbr = top_in;
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        gdd_cell #(
            .ROW_W (ROW_WIDTH),
            .MAX_R (MAX_RADIUS),
            .IDX   (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .d_in         (nbr),
            .radius_cells (radius_sq_reg[RSQ_W-1:RSQ_W-RADIUS_INT_W]),
            .q            (cell_q[i]),
            .contrib      (cell_contrib[i])
        );
    end

    always_comb begin
        dilated = '0;
        for (int i = 0; i <= WIN; i++) begin
            dilated = dilated | cell_contrib[i];
        end
        dilated = dilated & row_mask;
    end

    // sequencing of rows and end-of-frame flush
    always_comb begin
        rows_seen_next = rows_seen_reg;
        flushing_next  = flushing_reg;
        step_next      = step_reg;
        skip_next      = skip_reg;
        emit           = 1'b0;
        emit_last      = 1'b0;

        if (acc) begin
            emit = (rows_seen_reg == R_CNT);
            if (s_data.last_row) begin
                flushing_next  = 1'b1;
                step_next      = CNT_W'(1);
                skip_next      = R_CNT - rows_seen_reg;
                rows_seen_next = '0;
            end else if (rows_seen_reg != R_CNT) begin
                rows_seen_next = rows_seen_reg + CNT_W'(1);
            end
        end else if (flush_step) begin
            emit      = (step_reg >= skip_reg);
            emit_last = (step_reg == R_CNT);
            if (step_reg == R_CNT) begin
                flushing_next = 1'b0;
            end else begin
                step_next = step_reg + CNT_W'(1);
            end
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next         = 1'b1;
            out_data_next.out_row  = ROW_BITS'(dilated);
            out_data_next.out_last = emit_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_seen_reg <= '0;
            flushing_reg  <= 1'b0;
            step_reg      <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rows_seen_reg <= rows_seen_next;
            flushing_reg  <= flushing_next;
            step_reg      <= step_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // checks
    a_last_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && s_data.last_row |=> !s_ready)
        else $error("input taken right after a last-row transfer");

    a_final_row_frame_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_last |-> rows_seen_reg == '0 && !flushing_reg)
        else $error("final dilated row while frame state still live");

    a_rows_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_seen_reg <= R_CNT)
        else $error("rows_seen beyond MAX_RADIUS");

    a_flush_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flushing_reg |-> step_reg != '0 && step_reg <= R_CNT && rows_seen_reg == '0)
        else $error("flush step counter out of range");

endmodule
`default_nettype wire
